// ----- design/round_robin_task_scheduler_assert.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Consequent checked in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ----- design/rrts_pkg.sv -----
package rrts_pkg;

  // Field widths
  localparam int ACT_W     = 4;
  localparam int TASK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int PERIOD_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_TICK    = 4'd0;
  localparam logic [ACT_W-1:0] ACT_YIELD   = 4'd1;
  localparam logic [ACT_W-1:0] ACT_SWITCH  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_SUSPEND = 4'd3;
  localparam logic [ACT_W-1:0] ACT_RESUME  = 4'd4;
  localparam logic [ACT_W-1:0] ACT_BLOCK   = 4'd5;
  localparam logic [ACT_W-1:0] ACT_UNBLOCK = 4'd6;
  localparam logic [ACT_W-1:0] ACT_START   = 4'd7;
  localparam logic [ACT_W-1:0] ACT_STOP    = 4'd8;

  // Task status codes
  localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACTIVE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SUSPEND = 2'd3;

  // Register select (paddr bit 2)
  localparam logic REG_TASK_COUNT    = 1'b0;
  localparam logic REG_SWITCH_PERIOD = 1'b1;

  // Scheduler mode
  typedef enum logic [1:0] {
    MODE_INIT    = 2'd1,
    MODE_STARTED = 2'd2,
    MODE_STOPPED = 2'd3
  } mode_t;

endpackage

// ----- design/rrts_cmd_if.sv -----
interface rrts_cmd_if;
  logic                            valid;
  logic                            ready;
  logic [rrts_pkg::ACT_W-1:0]      action;
  logic                            use_running;
  logic [rrts_pkg::TASK_W-1:0]     task_index;

  modport source (output valid, action, use_running, task_index, input ready);
  modport sink   (input valid, action, use_running, task_index, output ready);
endinterface

// ----- design/rrts_rsp_if.sv -----
interface rrts_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [rrts_pkg::TASK_W-1:0]     running_task;
  logic [rrts_pkg::TASK_W-1:0]     proposed_task;
  logic                            switch_request;
  logic [rrts_pkg::STATUS_W-1:0]   task_state;
  logic                            accepted;

  modport source (output valid, running_task, proposed_task, switch_request, task_state,
                  accepted, input ready);
  modport sink   (input valid, running_task, proposed_task, switch_request, task_state,
                  accepted, output ready);
endinterface

// ----- design/rrts_status_mem.sv -----
module rrts_status_mem #(
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            we,
  input  logic [AW-1:0]                   waddr,
  input  logic [rrts_pkg::STATUS_W-1:0]   wdata,
  input  logic                            re,
  input  logic [AW-1:0]                   raddr,
  output logic [rrts_pkg::STATUS_W-1:0]   rdata
);

  logic [rrts_pkg::STATUS_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]              valid;

  // Write the status array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track written entries; unwritten ones read as idle
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : rrts_pkg::ST_IDLE;
    end
  end

endmodule

// ----- design/rrts_ring_step.sv -----
module rrts_ring_step (
  input  logic [rrts_pkg::COUNT_W-1:0] ptr,
  input  logic [rrts_pkg::COUNT_W-1:0] count,
  output logic [rrts_pkg::COUNT_W-1:0] nxt
);

  logic [rrts_pkg::COUNT_W:0] sum;

  // Advance one slot around the ring, wrapping to task 0
  always_comb begin
    sum = {1'b0, ptr} + (rrts_pkg::COUNT_W + 1)'(1);
    nxt = (sum >= {1'b0, count}) ? '0 : sum[rrts_pkg::COUNT_W-1:0];
  end

endmodule

// ----- design/round_robin_task_scheduler.sv -----
// Round-robin task scheduler.
// Items arrive on the cmd channel (action, use_running, task_index) and each
// produces exactly one word on the rsp channel (running_task, proposed_task,
// switch_request, task_state, accepted). task_count and switch_period are
// written over the APB port at byte addresses 0 and 4; write them while idle.
// The block takes one item at a time: cmd.ready is high only in the idle
// state. A status, start, stop, tick or ignored action goes through the
// execute, read and output states; a started switch also passes through
// the queued-task write, after the running-task check when that task is in
// range. A yield (or a tick that expires the period while started) adds a
// search of m probes, 1 to n, where n is the effective task count: the
// search reads one status entry per cycle through the single read port of
// the status memory, starting after the running task and stopping at the
// first idle one or after n probes. cmd.ready returns with the load.
// The response register holds its word until rsp.ready; while it is full the
// next result waits in the final state and no new item is taken.
// Reset clears the table to all idle (per-entry valid bits), sets running and
// pending to task 0, clears the tick counter, sets both registers to 1 and
// leaves the scheduler initialized but not started.
module round_robin_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rrts_pkg::PADDR_W-1:0]    paddr,
  input  logic [rrts_pkg::PDATA_W-1:0]    pwdata,
  output logic [rrts_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  rrts_cmd_if.sink                        cmd,
  rrts_rsp_if.source                      rsp
);

  localparam int IDX_W = $clog2(MAX_TASKS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_SEARCH = 7'b0000100,
    S_SW_CHK = 7'b0001000,
    S_SW_WQ  = 7'b0010000,
    S_READ   = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t                              state;
  rrts_pkg::mode_t                     mode;

  logic [rrts_pkg::COUNT_W-1:0]        task_count;
  logic [rrts_pkg::PERIOD_W-1:0]       switch_period;

  logic [rrts_pkg::ACT_W-1:0]          act;
  logic                                use_run;
  logic [rrts_pkg::TASK_W-1:0]         tidx;

  logic [rrts_pkg::TASK_W-1:0]         running;
  logic [rrts_pkg::TASK_W-1:0]         pending;
  logic [rrts_pkg::PERIOD_W-1:0]       tick_counter;
  logic [rrts_pkg::COUNT_W-1:0]        chk_ptr;
  logic [rrts_pkg::COUNT_W-1:0]        probe_cnt;
  logic                                req;
  logic                                acc;

  logic                                rsp_valid;
  logic [rrts_pkg::TASK_W-1:0]         rsp_running;
  logic [rrts_pkg::TASK_W-1:0]         rsp_proposed;
  logic                                rsp_req;
  logic [rrts_pkg::STATUS_W-1:0]       rsp_state;
  logic                                rsp_acc;

  logic [rrts_pkg::COUNT_W-1:0]        n;
  logic [rrts_pkg::TASK_W-1:0]         addr;
  logic                                addr_ok;
  logic                                r_ok;
  logic                                q_ok;
  logic                                started;
  logic [rrts_pkg::PERIOD_W-1:0]       tick_next;
  logic [rrts_pkg::PERIOD_W-1:0]       period;
  logic                                tick_wrap;
  logic [rrts_pkg::COUNT_W-1:0]        ring_in;
  logic [rrts_pkg::COUNT_W-1:0]        ring_out;

  logic                                mem_we;
  logic [IDX_W-1:0]                    mem_waddr;
  logic [rrts_pkg::STATUS_W-1:0]       mem_wdata;
  logic                                mem_re;
  logic [IDX_W-1:0]                    mem_raddr;
  logic [rrts_pkg::STATUS_W-1:0]       mem_rdata;

  // Effective task count, addressed task and timer decode
  always_comb begin
    if (task_count == '0) begin
      n = rrts_pkg::COUNT_W'(1);
    end else if (32'(task_count) > MAX_TASKS) begin
      n = rrts_pkg::COUNT_W'(MAX_TASKS);
    end else begin
      n = task_count;
    end
    addr      = use_run ? running : tidx;
    addr_ok   = {1'b0, addr} < n;
    r_ok      = 32'(running) < MAX_TASKS;
    q_ok      = 32'(pending) < MAX_TASKS;
    started   = (mode == rrts_pkg::MODE_STARTED);
    tick_next = tick_counter + rrts_pkg::PERIOD_W'(1);
    period    = (switch_period == '0) ? rrts_pkg::PERIOD_W'(1) : switch_period;
    tick_wrap = (tick_next >= period) || (tick_next == '0);
    ring_in   = (state == S_SEARCH) ? chk_ptr : {1'b0, running};
  end

  // Shared ring stepper: first probe from the running task, then each probe
  rrts_ring_step u_ring (
    .ptr   (ring_in),
    .count (n),
    .nxt   (ring_out)
  );

  rrts_status_mem #(
    .DEPTH (MAX_TASKS)
  ) u_status (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Status memory access per sequencer step
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = rrts_pkg::ST_IDLE;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_EXEC: begin
        case (act) inside
          rrts_pkg::ACT_TICK: begin
            if (tick_wrap && started) begin
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(ring_out);
            end
          end
          rrts_pkg::ACT_YIELD: begin
            if (started) begin
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(ring_out);
            end
          end
          rrts_pkg::ACT_SWITCH: begin
            if (started && r_ok) begin
              mem_re    = 1'b1;
              mem_raddr = IDX_W'(running);
            end
          end
          rrts_pkg::ACT_SUSPEND, rrts_pkg::ACT_BLOCK: begin
            mem_we    = addr_ok;
            mem_waddr = IDX_W'(addr);
            mem_wdata = (act == rrts_pkg::ACT_SUSPEND) ? rrts_pkg::ST_SUSPEND
                                                       : rrts_pkg::ST_BLOCKED;
          end
          rrts_pkg::ACT_RESUME, rrts_pkg::ACT_UNBLOCK: begin
            mem_we    = addr_ok;
            mem_waddr = IDX_W'(addr);
            mem_wdata = use_run ? rrts_pkg::ST_ACTIVE : rrts_pkg::ST_IDLE;
          end
          default: begin
          end
        endcase
      end
      S_SEARCH: begin
        mem_re    = 1'b1;
        mem_raddr = IDX_W'(ring_out);
      end
      S_SW_CHK: begin
        mem_we    = (mem_rdata == rrts_pkg::ST_ACTIVE);
        mem_waddr = IDX_W'(running);
        mem_wdata = rrts_pkg::ST_IDLE;
      end
      S_SW_WQ: begin
        mem_we    = q_ok;
        mem_waddr = IDX_W'(pending);
        mem_wdata = rrts_pkg::ST_ACTIVE;
      end
      S_READ: begin
        mem_re    = addr_ok;
        mem_raddr = IDX_W'(addr);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, scheduler state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      mode          <= rrts_pkg::MODE_INIT;
      task_count    <= rrts_pkg::COUNT_W'(1);
      switch_period <= rrts_pkg::PERIOD_W'(1);
      running       <= '0;
      pending       <= '0;
      tick_counter  <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      // Take register writes
      if (psel && penable && pwrite) begin
        unique case (paddr[2])
          rrts_pkg::REG_TASK_COUNT:    task_count    <= pwdata[rrts_pkg::COUNT_W-1:0];
          rrts_pkg::REG_SWITCH_PERIOD: switch_period <= pwdata[rrts_pkg::PERIOD_W-1:0];
          default: begin
          end
        endcase
      end

      // Drop the response word once taken, unless a new one loads now
      if (rsp_valid && rsp.ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            act     <= cmd.action;
            use_run <= cmd.use_running;
            tidx    <= cmd.task_index;
            req     <= 1'b0;
            acc     <= 1'b0;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= S_READ;
          case (act) inside
            rrts_pkg::ACT_TICK: begin
              acc <= 1'b1;
              if (tick_wrap) begin
                tick_counter <= '0;
                if (started) begin
                  req       <= 1'b1;
                  chk_ptr   <= ring_out;
                  probe_cnt <= '0;
                  state     <= S_SEARCH;
                end
              end else begin
                tick_counter <= tick_next;
              end
            end
            rrts_pkg::ACT_YIELD: begin
              if (started) begin
                acc       <= 1'b1;
                req       <= 1'b1;
                chk_ptr   <= ring_out;
                probe_cnt <= '0;
                state     <= S_SEARCH;
              end
            end
            rrts_pkg::ACT_SWITCH: begin
              if (started) begin
                acc   <= 1'b1;
                state <= r_ok ? S_SW_CHK : S_SW_WQ;
              end
            end
            rrts_pkg::ACT_SUSPEND, rrts_pkg::ACT_RESUME,
            rrts_pkg::ACT_BLOCK, rrts_pkg::ACT_UNBLOCK: begin
              acc <= addr_ok;
            end
            rrts_pkg::ACT_START: begin
              if (mode == rrts_pkg::MODE_INIT) begin
                running <= '0;
                pending <= '0;
                mode    <= rrts_pkg::MODE_STARTED;
                acc     <= 1'b1;
              end else if (mode == rrts_pkg::MODE_STOPPED) begin
                mode <= rrts_pkg::MODE_STARTED;
                acc  <= 1'b1;
              end
            end
            rrts_pkg::ACT_STOP: begin
              if (started) begin
                mode <= rrts_pkg::MODE_STOPPED;
                acc  <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        // One probe per cycle; stop at the first idle task or after n probes
        S_SEARCH: begin
          if (mem_rdata == rrts_pkg::ST_IDLE) begin
            pending <= chk_ptr[rrts_pkg::TASK_W-1:0];
            state   <= S_READ;
          end else if (probe_cnt == n - rrts_pkg::COUNT_W'(1)) begin
            pending <= ring_out[rrts_pkg::TASK_W-1:0];
            state   <= S_READ;
          end else begin
            chk_ptr   <= ring_out;
            probe_cnt <= probe_cnt + rrts_pkg::COUNT_W'(1);
          end
        end
        S_SW_CHK: begin
          state <= S_SW_WQ;
        end
        S_SW_WQ: begin
          running <= pending;
          state   <= S_READ;
        end
        S_READ: begin
          state <= S_OUT;
        end
        // Load the response register when it is free or its word is taken now
        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_running  <= running;
            rsp_proposed <= pending;
            rsp_req      <= req;
            rsp_state    <= addr_ok ? mem_rdata : rrts_pkg::ST_IDLE;
            rsp_acc      <= acc;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the channels and the register read port
  assign cmd.ready          = (state == S_IDLE);
  assign rsp.valid          = rsp_valid;
  assign rsp.running_task   = rsp_running;
  assign rsp.proposed_task  = rsp_proposed;
  assign rsp.switch_request = rsp_req;
  assign rsp.task_state     = rsp_state;
  assign rsp.accepted       = rsp_acc;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rrts_pkg::REG_TASK_COUNT)
                ? rrts_pkg::PDATA_W'(task_count)
                : rrts_pkg::PDATA_W'(switch_period);

  `include "round_robin_task_scheduler_assert.svh"

  `RRTS_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.valid && cmd.ready, !cmd.ready)
  `RRTS_ASSERT_SAME(a_rsp_from_out, clk, rst, $rose(rsp_valid), $past(state == S_OUT))
  `RRTS_ASSERT_SAME(a_req_accepted, clk, rst, rsp_valid && rsp_req, rsp_acc)

endmodule

// ----- test/round_robin_task_scheduler_checker.sv -----
module round_robin_task_scheduler_checker #(
  parameter int MAX_TASKS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [rrts_pkg::PADDR_W-1:0] paddr,
  input  logic [rrts_pkg::PDATA_W-1:0] pwdata,
  rrts_cmd_if                          cmd,
  rrts_rsp_if                          rsp,
  output int                           fail_count,
  output int                           outstanding,
  output int                           words_checked,
  output int                           switch_requests,
  output int                           ignored_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [rrts_pkg::TASK_W-1:0]   running_task;
    logic [rrts_pkg::TASK_W-1:0]   proposed_task;
    logic                          switch_request;
    logic [rrts_pkg::STATUS_W-1:0] task_state;
    logic                          accepted;
  } sched_word_t;

  // Shadow scheduler state
  logic [rrts_pkg::STATUS_W-1:0] status_tbl [16];
  logic [rrts_pkg::TASK_W-1:0]   cur_task;
  logic [rrts_pkg::TASK_W-1:0]   next_task;
  logic [rrts_pkg::PERIOD_W-1:0] tick_cnt;
  rrts_pkg::mode_t               sched_mode;
  logic [rrts_pkg::COUNT_W-1:0]  count_reg;
  logic [rrts_pkg::PERIOD_W-1:0] period_reg;
  sched_word_t                   sched_words_due [$];

  // Clamp the task count register to the usable ring size
  function automatic int ring_size();
    if (count_reg == 0) return 1;
    if (int'(count_reg) > MAX_TASKS) return MAX_TASKS;
    return int'(count_reg);
  endfunction

  function automatic int ring_after(int i, int n);
    return (i + 1 >= n) ? 0 : i + 1;
  endfunction

  // Walk the ring after the running task for the first idle entry
  function automatic void find_idle_task();
    int n;
    int p;
    n = ring_size();
    p = ring_after(int'(cur_task), n);
    for (int k = 0; k < n; k++) begin
      if (status_tbl[p] == rrts_pkg::ST_IDLE) break;
      p = ring_after(p, n);
    end
    next_task = p[rrts_pkg::TASK_W-1:0];
  endfunction

  // Advance the shadow state by one command and form the response word
  function automatic sched_word_t apply_action(logic [rrts_pkg::ACT_W-1:0] act,
                                               logic use_run,
                                               logic [rrts_pkg::TASK_W-1:0] idx);
    sched_word_t                   w;
    int                            n;
    logic [rrts_pkg::TASK_W-1:0]   target;
    logic [rrts_pkg::PERIOD_W-1:0] period;
    logic [rrts_pkg::PERIOD_W-1:0] cnt_next;
    n = ring_size();
    target = use_run ? cur_task : idx;
    w = '0;
    case (act)
      rrts_pkg::ACT_TICK: begin
        period = (period_reg == 0) ? rrts_pkg::PERIOD_W'(1) : period_reg;
        cnt_next = tick_cnt + 1'b1;
        w.accepted = 1'b1;
        if (cnt_next >= period || cnt_next == 0) begin
          tick_cnt = '0;
          if (sched_mode == rrts_pkg::MODE_STARTED) begin
            find_idle_task();
            w.switch_request = 1'b1;
          end
        end else begin
          tick_cnt = cnt_next;
        end
      end
      rrts_pkg::ACT_YIELD: begin
        if (sched_mode == rrts_pkg::MODE_STARTED) begin
          find_idle_task();
          w.switch_request = 1'b1;
          w.accepted = 1'b1;
        end
      end
      rrts_pkg::ACT_SWITCH: begin
        // old task drops to idle only if it was still active
        if (sched_mode == rrts_pkg::MODE_STARTED) begin
          if (status_tbl[cur_task] == rrts_pkg::ST_ACTIVE)
            status_tbl[cur_task] = rrts_pkg::ST_IDLE;
          status_tbl[next_task] = rrts_pkg::ST_ACTIVE;
          cur_task = next_task;
          w.accepted = 1'b1;
        end
      end
      rrts_pkg::ACT_SUSPEND, rrts_pkg::ACT_BLOCK: begin
        if (int'(target) < n) begin
          status_tbl[target] = (act == rrts_pkg::ACT_SUSPEND) ? rrts_pkg::ST_SUSPEND
                                                              : rrts_pkg::ST_BLOCKED;
          w.accepted = 1'b1;
        end
      end
      rrts_pkg::ACT_RESUME, rrts_pkg::ACT_UNBLOCK: begin
        if (int'(target) < n) begin
          status_tbl[target] = use_run ? rrts_pkg::ST_ACTIVE : rrts_pkg::ST_IDLE;
          w.accepted = 1'b1;
        end
      end
      rrts_pkg::ACT_START: begin
        if (sched_mode == rrts_pkg::MODE_INIT) begin
          cur_task = '0;
          next_task = '0;
          sched_mode = rrts_pkg::MODE_STARTED;
          w.accepted = 1'b1;
        end else if (sched_mode == rrts_pkg::MODE_STOPPED) begin
          sched_mode = rrts_pkg::MODE_STARTED;
          w.accepted = 1'b1;
        end
      end
      rrts_pkg::ACT_STOP: begin
        if (sched_mode == rrts_pkg::MODE_STARTED) begin
          sched_mode = rrts_pkg::MODE_STOPPED;
          w.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    target = use_run ? cur_task : idx;
    w.running_task = cur_task;
    w.proposed_task = next_task;
    w.task_state = (int'(target) < n) ? status_tbl[target] : rrts_pkg::ST_IDLE;
    return w;
  endfunction

  // Watch both channels and the register port
  always @(posedge clk) begin
    sched_word_t got;
    sched_word_t want;
    if (rst) begin
      foreach (status_tbl[i]) status_tbl[i] = rrts_pkg::ST_IDLE;
      cur_task = '0;
      next_task = '0;
      tick_cnt = '0;
      sched_mode = rrts_pkg::MODE_INIT;
      count_reg = rrts_pkg::COUNT_W'(1);
      period_reg = rrts_pkg::PERIOD_W'(1);
      sched_words_due.delete();
      fail_count = 0;
      words_checked = 0;
      switch_requests = 0;
      ignored_words = 0;
    end else begin
      // compare the response word with the oldest prediction
      if (rsp.valid && rsp.ready) begin
        got = {rsp.running_task, rsp.proposed_task, rsp.switch_request, rsp.task_state,
               rsp.accepted};
        if (sched_words_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display({"%0t: response word with nothing predicted:",
                      " run %0d prop %0d req %0b st %0d acc %0b"},
                     $realtime, got.running_task, got.proposed_task, got.switch_request,
                     got.task_state, got.accepted);
        end else begin
          want = sched_words_due.pop_front();
          words_checked++;
          if (got.switch_request) switch_requests++;
          if (!got.accepted) ignored_words++;
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"%0t: mismatch, expected run %0d prop %0d req %0b st %0d acc %0b,",
                        " got run %0d prop %0d req %0b st %0d acc %0b"},
                       $realtime, want.running_task, want.proposed_task,
                       want.switch_request, want.task_state, want.accepted,
                       got.running_task, got.proposed_task, got.switch_request,
                       got.task_state, got.accepted);
          end
        end
      end
      // predict each accepted command word
      if (cmd.valid && cmd.ready)
        sched_words_due.push_back(apply_action(cmd.action, cmd.use_running, cmd.task_index));
      // track register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == rrts_pkg::REG_TASK_COUNT) count_reg = pwdata[rrts_pkg::COUNT_W-1:0];
        else period_reg = pwdata[rrts_pkg::PERIOD_W-1:0];
      end
    end
    outstanding <= sched_words_due.size();
  end

endmodule

// ----- test/round_robin_task_scheduler_tb.sv -----
module round_robin_task_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_TASKS      = 16;
  localparam int RANDOM_WORDS = 1250;
  localparam int PHASES       = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_PCT    = 29;

  // Action codes outside the defined set
  localparam logic [rrts_pkg::ACT_W-1:0] ACT_UNUSED_LO = 4'd9;
  localparam logic [rrts_pkg::ACT_W-1:0] ACT_UNUSED_HI = 4'd15;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [rrts_pkg::PADDR_W-1:0] paddr;
  logic [rrts_pkg::PDATA_W-1:0] pwdata;
  logic [rrts_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  rrts_cmd_if cmd_bus ();
  rrts_rsp_if rsp_bus ();

  int                           fail_count;
  int                           outstanding;
  int                           words_checked;
  int                           switch_requests;
  int                           ignored_words;
  int                           cycle_count = 0;
  int                           settings_done = 1;
  bit                           no_stall = 1'b0;
  logic [rrts_pkg::COUNT_W-1:0] ring_cfg = rrts_pkg::COUNT_W'(1);

  round_robin_task_scheduler #(
    .MAX_TASKS(N_TASKS)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cmd    (cmd_bus),
    .rsp    (rsp_bus)
  );

  round_robin_task_scheduler_checker #(
    .MAX_TASKS(N_TASKS)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .cmd            (cmd_bus),
    .rsp            (rsp_bus),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .words_checked  (words_checked),
    .switch_requests(switch_requests),
    .ignored_words  (ignored_words)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the response side at random, except in the quiet phase
  always @(posedge clk) begin
    rsp_bus.ready <= no_stall || ($urandom_range(99) >= STALL_PCT);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offer one command word and hold it until taken
  task automatic send_word(input logic [rrts_pkg::ACT_W-1:0] act, input logic use_run,
                           input logic [rrts_pkg::TASK_W-1:0] idx);
    while (!no_stall && $urandom_range(99) < STALL_PCT) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_bus.valid       <= 1'b1;
    cmd_bus.action      <= act;
    cmd_bus.use_running <= use_run;
    cmd_bus.task_index  <= idx;
    do @(posedge clk); while (!cmd_bus.ready);
  endtask

  // Hold off until every predicted response word has arrived
  task automatic drain();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic sel, input logic [rrts_pkg::PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [rrts_pkg::COUNT_W-1:0] count,
                            input logic [rrts_pkg::PERIOD_W-1:0] period);
    drain();
    write_reg(rrts_pkg::REG_TASK_COUNT, rrts_pkg::PDATA_W'(count));
    write_reg(rrts_pkg::REG_SWITCH_PERIOD, rrts_pkg::PDATA_W'(period));
    ring_cfg = count;
    settings_done++;
  endtask

  // Pick a weighted action; mostly address tasks inside the ring
  task automatic send_random_word();
    int                          n;
    int                          roll;
    logic [rrts_pkg::ACT_W-1:0]  act;
    logic                        use_run;
    logic [rrts_pkg::TASK_W-1:0] idx;
    n = (ring_cfg == 0) ? 1 : ((int'(ring_cfg) > N_TASKS) ? N_TASKS : int'(ring_cfg));
    roll = $urandom_range(99);
    use_run = ($urandom_range(99) < 25);
    idx = ($urandom_range(99) < 80) ? rrts_pkg::TASK_W'($urandom_range(n - 1))
                                    : rrts_pkg::TASK_W'($urandom_range(15));
    if (roll < 25) act = rrts_pkg::ACT_TICK;
    else if (roll < 40) act = rrts_pkg::ACT_YIELD;
    else if (roll < 55) act = rrts_pkg::ACT_SWITCH;
    else if (roll < 63) act = rrts_pkg::ACT_SUSPEND;
    else if (roll < 71) act = rrts_pkg::ACT_RESUME;
    else if (roll < 79) act = rrts_pkg::ACT_BLOCK;
    else if (roll < 87) act = rrts_pkg::ACT_UNBLOCK;
    else if (roll < 93) act = rrts_pkg::ACT_START;
    else if (roll < 97) act = rrts_pkg::ACT_STOP;
    else act = rrts_pkg::ACT_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
    send_word(act, use_run, idx);
    // follow most yields with the matching switch
    if (act == rrts_pkg::ACT_YIELD && $urandom_range(99) < 60)
      send_word(rrts_pkg::ACT_SWITCH, 1'b0, idx);
  endtask

  initial begin
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cmd_bus.valid       = 1'b0;
    cmd_bus.action      = rrts_pkg::ACT_TICK;
    cmd_bus.use_running = 1'b0;
    cmd_bus.task_index  = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // before start, with the reset ring of one task
    send_word(rrts_pkg::ACT_YIELD, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_SWITCH, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_STOP, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_TICK, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_SUSPEND, 1'b0, 4'd3);
    send_word(ACT_UNUSED_LO, 1'b0, 4'd0);
    send_word(ACT_UNUSED_HI, 1'b1, 4'd15);
    send_word(rrts_pkg::ACT_START, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_START, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_TICK, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_RESUME, 1'b1, 4'd0);

    // full ring, zero period
    set_config(rrts_pkg::COUNT_W'(N_TASKS), '0);
    send_word(rrts_pkg::ACT_BLOCK, 1'b0, 4'd15);
    send_word(rrts_pkg::ACT_SUSPEND, 1'b1, 4'd0);
    send_word(rrts_pkg::ACT_RESUME, 1'b1, 4'd0);
    send_word(rrts_pkg::ACT_UNBLOCK, 1'b0, 4'd15);
    send_word(rrts_pkg::ACT_SWITCH, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_YIELD, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_SWITCH, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_TICK, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_STOP, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_STOP, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_TICK, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_START, 1'b0, 4'd0);
    send_word(rrts_pkg::ACT_RESUME, 1'b0, 4'd9);
    send_word(rrts_pkg::ACT_BLOCK, 1'b1, 4'd0);

    // random phases over several register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(rrts_pkg::COUNT_W'(4), rrts_pkg::PERIOD_W'(2));
        1: set_config('0, rrts_pkg::PERIOD_W'(1));
        2: set_config('1, '1);
        3: set_config(rrts_pkg::COUNT_W'(2), rrts_pkg::PERIOD_W'(3));
        4: set_config(rrts_pkg::COUNT_W'(17), '0);
        5: set_config(rrts_pkg::COUNT_W'(1), rrts_pkg::PERIOD_W'(1));
        default: set_config(rrts_pkg::COUNT_W'($urandom_range(16, 1)),
                            rrts_pkg::PERIOD_W'($urandom_range(8, 1)));
      endcase
      no_stall <= (ph == 6);
      send_word(rrts_pkg::ACT_START, 1'b0, 4'd0);
      for (int k = 0; k < RANDOM_WORDS / PHASES; k++) send_random_word();
    end

    drain();
    no_stall <= 1'b0;
    repeat (40) @(posedge clk);
    $display("run covered %0d response words across %0d register settings",
             words_checked, settings_done);
    $display("including %0d switch requests and %0d ignored actions",
             switch_requests, ignored_words);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- round_robin_task_scheduler.f -----
+incdir+design
design/rrts_pkg.sv
design/rrts_cmd_if.sv
design/rrts_rsp_if.sv
design/rrts_status_mem.sv
design/rrts_ring_step.sv
design/round_robin_task_scheduler.sv
test/round_robin_task_scheduler_checker.sv
test/round_robin_task_scheduler_tb.sv
